// ===== rtl/rwgf_pkg.sv =====
package rwgf_pkg;

   localparam int NUM_SAMPLES = 5;
   // Working row: history distance followed by the five samples.
   localparam int ROW_LEN     = NUM_SAMPLES + 1;

   localparam logic [15:0] MISSING_MARK = 16'hFFFF;
   localparam logic [15:0] FILL_FLAG    = 16'h8000;
   localparam logic [15:0] VALUE_MASK   = 16'h7FFF;

   // ceil(2^17 / 3); exact floor(x / 3) for any x below 2^16
   localparam logic [16:0] THIRD_RECIP  = 17'h0AAAB;

   typedef logic [15:0] sample_type;

   // Queue entry handed from the front to the back end.
   typedef struct packed {
      sample_type [NUM_SAMPLES-1:0] samples;
      logic                         skip;     // last two samples missing
   } job_type;

   function automatic logic [14:0] div_by_three(input logic [14:0] x);
      logic [31:0] prod;
      prod = {17'b0, x} * {15'b0, THIRD_RECIP};
      return prod[31:17];
   endfunction

endpackage

// ===== rtl/rwgf_front.sv =====
module rwgf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rwgf_pkg::sample_type req_sample_0,
   input  rwgf_pkg::sample_type req_sample_1,
   input  rwgf_pkg::sample_type req_sample_2,
   input  rwgf_pkg::sample_type req_sample_3,
   input  rwgf_pkg::sample_type req_sample_4,
   output logic                 job_valid,
   output rwgf_pkg::job_type    job,
   input  logic                 job_pop
);
   import rwgf_pkg::*;

   // two-entry queue
   job_type    q_ff [0:1];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   job_type    entry;

   always_comb begin
      entry.samples[0] = req_sample_0;
      entry.samples[1] = req_sample_1;
      entry.samples[2] = req_sample_2;
      entry.samples[3] = req_sample_3;
      entry.samples[4] = req_sample_4;
      entry.skip = (req_sample_3 == MISSING_MARK) && (req_sample_4 == MISSING_MARK);
   end

   assign req_stall = (count_ff == 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = job_pop && job_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== rtl/rwgf_back.sv =====
module rwgf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  rwgf_pkg::job_type    job,
   output logic                 job_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rwgf_pkg::sample_type rsp_out_0,
   output rwgf_pkg::sample_type rsp_out_1,
   output rwgf_pkg::sample_type rsp_out_2,
   output rwgf_pkg::sample_type rsp_out_3,
   output rwgf_pkg::sample_type rsp_out_4,
   output logic                 rsp_repaired
);
   import rwgf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_DIFF = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_FILL = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   localparam logic [2:0] LAST_POS = 3'(ROW_LEN - 1);

   state_type   state_ff, state_in;
   sample_type  row_ff [0:ROW_LEN-1];
   sample_type  row_in [0:ROW_LEN-1];
   logic [2:0]  scan_ff, scan_in;
   logic [2:0]  gap_start_ff, gap_start_in;
   logic [2:0]  gap_count_ff, gap_count_in;
   logic [2:0]  fill_ptr_ff, fill_ptr_in;
   logic [2:0]  fill_left_ff, fill_left_in;
   sample_type  lo_ff, lo_in;        // value in front of the gap
   sample_type  close_ff, close_in;  // value closing the gap
   sample_type  prev_ff, prev_in;    // last written fill value
   logic [14:0] diff_ff, diff_in;
   logic [14:0] step_ff, step_in;
   logic        rising_ff, rising_in;
   logic        equal_ff, equal_in;
   logic        rep_ff, rep_in;
   sample_type  hist_ff, hist_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sample_type  out_ff [0:NUM_SAMPLES-1];
   sample_type  out_in [0:NUM_SAMPLES-1];
   logic        repaired_ff, repaired_in;

   sample_type  raw [0:ROW_LEN-1];
   sample_type  filled [0:ROW_LEN-1];
   logic        end_fail;
   sample_type  scan_val;
   sample_type  fill_val;
   logic        out_free;

   // end filling of the row taken from the queue head
   always_comb begin
      sample_type lead;
      logic       found;
      logic       hit;
      lead  = MISSING_MARK;
      found = 1'b0;
      hit   = 1'b0;
      raw[0] = hist_ff;
      for (int k = 0; k < NUM_SAMPLES; k++) begin
         raw[k+1] = job.samples[k];
      end
      for (int k = 0; k < ROW_LEN; k++) begin
         filled[k] = raw[k];
      end
      // trailing gap: row[4] is valid whenever row[5] is missing and the job is not skipped
      if (filled[ROW_LEN-1] == MISSING_MARK) begin
         filled[ROW_LEN-1] = filled[ROW_LEN-2] | FILL_FLAG;
      end
      // leading gap only without history
      if (filled[0] == MISSING_MARK) begin
         for (int k = 0; k < ROW_LEN; k++) begin
            if (!found && filled[k] != MISSING_MARK) begin
               found = 1'b1;
               lead  = filled[k] | FILL_FLAG;
            end
         end
         for (int k = 0; k < ROW_LEN; k++) begin
            if (!hit) begin
               if (filled[k] != MISSING_MARK) begin
                  hit = 1'b1;
               end else if (found) begin
                  filled[k] = lead;
               end
            end
         end
      end
      end_fail = job.skip || (filled[0] == MISSING_MARK)
               || (filled[ROW_LEN-1] == MISSING_MARK);
   end

   assign scan_val = row_ff[scan_ff];

   // one step of the linear fill
   always_comb begin
      logic [14:0] p;
      logic [15:0] sum;
      p   = prev_ff[14:0];
      sum = {1'b0, p} + {1'b0, step_ff};
      if (equal_ff) begin
         fill_val = close_ff | FILL_FLAG;
      end else if (rising_ff) begin
         fill_val = sum | FILL_FLAG;
      end else if (p > step_ff) begin
         fill_val = {1'b0, p - step_ff} | FILL_FLAG;
      end else begin
         fill_val = prev_ff | FILL_FLAG;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      gap_start_in = gap_start_ff;
      gap_count_in = gap_count_ff;
      fill_ptr_in  = fill_ptr_ff;
      fill_left_in = fill_left_ff;
      lo_in        = lo_ff;
      close_in     = close_ff;
      prev_in      = prev_ff;
      diff_in      = diff_ff;
      step_in      = step_ff;
      rising_in    = rising_ff;
      equal_in     = equal_ff;
      rep_in       = rep_ff;
      hist_in      = hist_ff;
      repaired_in  = repaired_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      job_pop      = 1'b0;
      for (int k = 0; k < ROW_LEN; k++) begin
         row_in[k] = row_ff[k];
      end
      for (int k = 0; k < NUM_SAMPLES; k++) begin
         out_in[k] = out_ff[k];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               if (end_fail) begin
                  for (int k = 0; k < ROW_LEN; k++) begin
                     row_in[k] = raw[k];
                  end
                  rep_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  for (int k = 0; k < ROW_LEN; k++) begin
                     row_in[k] = filled[k];
                  end
                  rep_in       = 1'b1;
                  lo_in        = filled[0];
                  scan_in      = 3'd1;
                  gap_count_in = 3'd0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_val == MISSING_MARK) begin
               if (gap_count_ff == 3'd0) begin
                  gap_start_in = scan_ff;
               end
               gap_count_in = gap_count_ff + 3'd1;
               if (scan_ff == LAST_POS) begin
                  state_in = ST_DONE;
               end else begin
                  scan_in = scan_ff + 3'd1;
               end
            end else if (gap_count_ff != 3'd0) begin
               close_in = scan_val;
               state_in = ST_DIFF;
            end else begin
               lo_in = scan_val;
               if (scan_ff == LAST_POS) begin
                  state_in = ST_DONE;
               end else begin
                  scan_in = scan_ff + 3'd1;
               end
            end
         end
         ST_DIFF: begin
            rising_in    = close_ff[14:0] > lo_ff[14:0];
            equal_in     = close_ff[14:0] == lo_ff[14:0];
            diff_in      = (close_ff[14:0] > lo_ff[14:0]) ? close_ff[14:0] - lo_ff[14:0]
                                                          : lo_ff[14:0] - close_ff[14:0];
            prev_in      = lo_ff;
            fill_ptr_in  = gap_start_ff;
            fill_left_in = gap_count_ff;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            // a single missing sample steps by half the difference
            case (gap_count_ff) inside
               3'd1, 3'd2: step_in = diff_ff >> 1;
               3'd3:       step_in = div_by_three(diff_ff);
               default:    step_in = diff_ff >> 2;
            endcase
            state_in = ST_FILL;
         end
         ST_FILL: begin
            row_in[fill_ptr_ff] = fill_val;
            prev_in             = fill_val;
            fill_ptr_in         = fill_ptr_ff + 3'd1;
            fill_left_in        = fill_left_ff - 3'd1;
            if (fill_left_ff == 3'd1) begin
               lo_in        = close_ff;
               gap_count_in = 3'd0;
               if (scan_ff == LAST_POS) begin
                  state_in = ST_DONE;
               end else begin
                  scan_in  = scan_ff + 3'd1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               for (int k = 0; k < NUM_SAMPLES; k++) begin
                  out_in[k] = row_ff[k+1];
               end
               repaired_in = rep_ff;
               hist_in     = rep_ff ? (row_ff[2] & VALUE_MASK) : MISSING_MARK;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hist_ff      <= MISSING_MARK;
         rsp_valid_ff <= 1'b0;
         gap_count_ff <= 3'd0;
      end else begin
         state_ff     <= state_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
         gap_count_ff <= gap_count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROW_LEN; k++) begin
         row_ff[k] <= row_in[k];
      end
      for (int k = 0; k < NUM_SAMPLES; k++) begin
         out_ff[k] <= out_in[k];
      end
      scan_ff      <= scan_in;
      gap_start_ff <= gap_start_in;
      fill_ptr_ff  <= fill_ptr_in;
      fill_left_ff <= fill_left_in;
      lo_ff        <= lo_in;
      close_ff     <= close_in;
      prev_ff      <= prev_in;
      diff_ff      <= diff_in;
      step_ff      <= step_in;
      rising_ff    <= rising_in;
      equal_ff     <= equal_in;
      rep_ff       <= rep_in;
      repaired_ff  <= repaired_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_0    = out_ff[0];
   assign rsp_out_1    = out_ff[1];
   assign rsp_out_2    = out_ff[2];
   assign rsp_out_3    = out_ff[3];
   assign rsp_out_4    = out_ff[4];
   assign rsp_repaired = repaired_ff;

endmodule

// ===== rtl/ranging_window_gap_fill.sv =====
// Flow: the back end works on one window at a time; it pops the next from the queue
//   only after the last result is in the response register, which waits while
//   rsp_stall holds a pending response. Passed-through windows skip the walk over
//   row positions, which paces the others.
// Reset (synchronous, active high): queue emptied, no response pending, history
//   distance set to 0xFFFF (no history).
module ranging_window_gap_fill (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rwgf_pkg::sample_type req_sample_0,
   input  rwgf_pkg::sample_type req_sample_1,
   input  rwgf_pkg::sample_type req_sample_2,
   input  rwgf_pkg::sample_type req_sample_3,
   input  rwgf_pkg::sample_type req_sample_4,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rwgf_pkg::sample_type rsp_out_0,
   output rwgf_pkg::sample_type rsp_out_1,
   output rwgf_pkg::sample_type rsp_out_2,
   output rwgf_pkg::sample_type rsp_out_3,
   output rwgf_pkg::sample_type rsp_out_4,
   output logic                 rsp_repaired
);
   import rwgf_pkg::*;

   // Front end: takes requests into a two-entry queue and flags windows
   // whose last two samples are missing, so the back end passes them on.
   logic    job_valid;
   job_type job;
   logic    job_pop;

   rwgf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_0 (req_sample_0),
      .req_sample_1 (req_sample_1),
      .req_sample_2 (req_sample_2),
      .req_sample_3 (req_sample_3),
      .req_sample_4 (req_sample_4),
      .job_valid    (job_valid),
      .job          (job),
      .job_pop      (job_pop)
   );

   // Back end: owns the history distance. On pop it builds the six-entry
   // row (history + samples) and fills the trailing and leading gaps as it
   // loads the row. It then scans positions 1..5; when a gap closes it forms the
   // difference, the step (shift, or reciprocal multiply for a gap of
   // three) and writes one filled sample per cycle. The result register
   // decouples it from the response side, so the front keeps queueing.
   rwgf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job          (job),
      .job_pop      (job_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_0    (rsp_out_0),
      .rsp_out_1    (rsp_out_1),
      .rsp_out_2    (rsp_out_2),
      .rsp_out_3    (rsp_out_3),
      .rsp_out_4    (rsp_out_4),
      .rsp_repaired (rsp_repaired)
   );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import rwgf_pkg::*;

   // Drive-side limits
   localparam int HOLD_CYCLES   = 80;        // long receiver hold-off
   localparam int DRAIN_CYCLES  = 20;        // quiet time after the last response
   localparam int RUN_LIMIT_NS  = 2_000_000; // well above the slowest legal run

   // One predicted response: out[k] lines up with rsp_out_k.
   typedef struct packed {
      sample_type [NUM_SAMPLES-1:0] out;
      logic                         repaired;
   } window_result_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   sample_type req_sample_0;
   sample_type req_sample_1;
   sample_type req_sample_2;
   sample_type req_sample_3;
   sample_type req_sample_4;
   logic       rsp_valid;
   logic       rsp_stall;
   sample_type rsp_out_0;
   sample_type rsp_out_1;
   sample_type rsp_out_2;
   sample_type rsp_out_3;
   sample_type rsp_out_4;
   logic       rsp_repaired;

   ranging_window_gap_fill u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample_0 (req_sample_0),
      .req_sample_1 (req_sample_1),
      .req_sample_2 (req_sample_2),
      .req_sample_3 (req_sample_3),
      .req_sample_4 (req_sample_4),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_0    (rsp_out_0),
      .rsp_out_1    (rsp_out_1),
      .rsp_out_2    (rsp_out_2),
      .rsp_out_3    (rsp_out_3),
      .rsp_out_4    (rsp_out_4),
      .rsp_repaired (rsp_repaired)
   );

   // Predicted responses, oldest first, plus the predictor's own history distance.
   window_result_type repaired_window_q[$];
   sample_type        model_history;

   int  error_count;
   int  request_count;
   int  response_count;
   int  repaired_count;
   int  passthru_count;

   // Idling controls, set by the test tasks; hold_served by the stall driver.
   bit  req_idle_on;
   bit  rsp_idle_on;
   int  hold_asked;   // bumped by a test to ask for one long hold-off
   int  hold_served;  // bumped by the stall driver when it starts one

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor: repairs one window against the running history distance.
   // Row position 0 is the history, positions 1..5 are sample_0..sample_4.
   // ------------------------------------------------------------------
   function automatic window_result_type repair_window(input sample_type [NUM_SAMPLES-1:0] win,
                                                       inout sample_type hist);
      window_result_type res;
      sample_type        row [ROW_LEN];
      sample_type        lo, hi, diff, step, divisor, prev;
      int                i, j, x, gap_start, gap_len;
      bit                found;

      res.out      = win;
      res.repaired = 1'b0;

      // Newest two both missing: nothing to anchor on, pass through.
      if (win[3] == MISSING_MARK && win[4] == MISSING_MARK) begin
         hist = MISSING_MARK;
         return res;
      end

      row[0] = hist;
      for (i = 0; i < NUM_SAMPLES; i++)
         row[i+1] = win[i];

      // Trailing gaps take the last valid value, flagged.
      found = 1'b0;
      for (i = ROW_LEN - 1; i > 0; i--) begin
         if (!found && row[i] != MISSING_MARK) begin
            found = 1'b1;
            for (j = i + 1; j < ROW_LEN; j++)
               row[j] = row[i] | FILL_FLAG;
         end
      end

      // Leading gaps only when there is no history; they take the first valid value.
      if (row[0] == MISSING_MARK) begin
         found = 1'b0;
         for (i = 0; i < ROW_LEN; i++) begin
            if (!found && row[i] != MISSING_MARK) begin
               found = 1'b1;
               for (j = 0; j < i; j++)
                  row[j] = row[i] | FILL_FLAG;
            end
         end
      end

      // A 0x7FFF source fills as 0xFFFF and reads as missing again.
      if (row[0] == MISSING_MARK || row[ROW_LEN-1] == MISSING_MARK) begin
         hist = MISSING_MARK;
         return res;
      end

      // Inner gaps: linear walk from the value before toward the value after.
      gap_start = 0;
      gap_len   = 0;
      for (i = 1; i < ROW_LEN; i++) begin
         if (row[i] == MISSING_MARK) begin
            if (gap_len == 0)
               gap_start = i;
            gap_len++;
         end else if (gap_len != 0) begin
            lo = row[gap_start-1] & VALUE_MASK;
            hi = row[i] & VALUE_MASK;
            if (hi == lo) begin
               for (x = 0; x < gap_len; x++)
                  row[gap_start+x] = row[i] | FILL_FLAG;
            end else begin
               divisor = (gap_len == 1) ? 16'd2 : sample_type'(gap_len);
               diff    = (hi > lo) ? (hi - lo) : (lo - hi);
               step    = diff / divisor;
               for (x = 0; x < gap_len; x++) begin
                  prev = row[gap_start+x-1] & VALUE_MASK;
                  if (hi > lo)
                     row[gap_start+x] = (prev + step) | FILL_FLAG;
                  else if (prev > step)
                     row[gap_start+x] = (prev - step) | FILL_FLAG;
                  else
                     // falling floor: hold the previous value
                     row[gap_start+x] = row[gap_start+x-1] | FILL_FLAG;
               end
            end
            gap_len = 0;
         end
      end

      hist = row[2] & VALUE_MASK;
      for (i = 0; i < NUM_SAMPLES; i++)
         res.out[i] = row[i+1];
      res.repaired = 1'b1;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Request monitor: predict on every accepted request, in order.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         repaired_window_q.push_back(repair_window({req_sample_4, req_sample_3, req_sample_2,
                                                    req_sample_1, req_sample_0},
                                                   model_history));
         request_count++;
      end
   end

   task automatic report_mismatch(input string what, input sample_type got,
                                  input sample_type want);
      $display("%0t ns: MISMATCH %s: got %h expected %h (response %0d)",
               $time, what, got, want, response_count);
      error_count++;
   endtask

   task automatic check_field(input string what, input sample_type got, input sample_type want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // ------------------------------------------------------------------
   // Response checker: compare every accepted response with the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (repaired_window_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_out_0, MISSING_MARK);
         end else begin
            want = repaired_window_q.pop_front();
            check_field("out_0", rsp_out_0, want.out[0]);
            check_field("out_1", rsp_out_1, want.out[1]);
            check_field("out_2", rsp_out_2, want.out[2]);
            check_field("out_3", rsp_out_3, want.out[3]);
            check_field("out_4", rsp_out_4, want.out[4]);
            check_field("repaired", {15'd0, rsp_repaired}, {15'd0, want.repaired});
            if (want.repaired)
               repaired_count++;
            else
               passthru_count++;
         end
         response_count++;
      end
   end

   // ------------------------------------------------------------------
   // Receiver stall driver: random bursts, plus a counted long hold-off on request.
   // ------------------------------------------------------------------
   initial begin : rsp_stall_driver
      int burst_left;
      int hold_left;
      bit stall_next;
      burst_left  = 0;
      hold_left   = 0;
      hold_served = 0;
      rsp_stall   = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_served != hold_asked) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
         end
         if (hold_left > 0) begin
            stall_next = 1'b1;
            hold_left--;
         end else if (burst_left > 0) begin
            stall_next = 1'b1;
            burst_left--;
         end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            stall_next = 1'b1;
            burst_left = $urandom_range(1, 7) - 1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // ------------------------------------------------------------------
   // Sender: one request per call; returns on the edge that accepts it.
   // valid stays high into the next call unless a gap is taken.
   // ------------------------------------------------------------------
   task automatic send_window(input sample_type s0, input sample_type s1, input sample_type s2,
                              input sample_type s3, input sample_type s4);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_sample_0 <= s0;
      req_sample_1 <= s1;
      req_sample_2 <= s2;
      req_sample_3 <= s3;
      req_sample_4 <= s4;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // Drop valid and wait for every predicted response to come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (repaired_window_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic sample_type random_sample();
      sample_type v;
      case ($urandom_range(0, 11))
         0, 1, 2: v = MISSING_MARK;
         3:       v = sample_type'($urandom_range(0, 64));
         4: begin
            case ($urandom_range(0, 4))
               0:       v = 16'h0000;
               1:       v = 16'h7FFF;
               2:       v = 16'h7FFE;
               3:       v = 16'h8000;
               default: v = 16'hFFFE;
            endcase
         end
         5:       v = sample_type'($urandom_range(0, 16'hFFFF));
         6:       v = FILL_FLAG | sample_type'($urandom_range(0, 16'h7FFF));
         default: v = sample_type'($urandom_range(0, 16'h7FFF));
      endcase
      return v;
   endfunction

   // Mostly smooth tracks with dropouts (the interesting repair paths), some noise.
   task automatic send_random_window();
      sample_type s [NUM_SAMPLES];
      int         base, slope, v, i;
      if ($urandom_range(0, 9) < 6) begin
         base  = $urandom_range(0, 16'h7FFF);
         slope = int'($urandom_range(0, 800)) - 400;
         for (i = 0; i < NUM_SAMPLES; i++) begin
            v = base + i * slope;
            if (v < 0)
               v = 0;
            if (v > 16'h7FFF)
               v = 16'h7FFF;
            s[i] = ($urandom_range(0, 9) < 3) ? MISSING_MARK : sample_type'(v);
         end
      end else begin
         for (i = 0; i < NUM_SAMPLES; i++)
            s[i] = random_sample();
      end
      send_window(s[0], s[1], s[2], s[3], s[4]);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-picked windows; comments note the history going in.
   task automatic test_directed_windows();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      // no history: clean window sets it
      send_window(16'd100, 16'd200, 16'd300, 16'd400, 16'd500);
      // history valid: leading gap bounded by the history
      send_window(MISSING_MARK, 16'd250, 16'd300, 16'd350, 16'd400);
      // newest two missing: pass through, history dropped
      send_window(16'd1, 16'd2, 16'd3, MISSING_MARK, MISSING_MARK);
      // no history: leading gaps copy the first valid sample
      send_window(MISSING_MARK, MISSING_MARK, 16'd500, 16'd600, 16'd700);
      // trailing fill from the last valid sample
      send_window(16'd10, 16'd20, 16'd30, 16'd40, MISSING_MARK);
      // single gap, rising, step is half the difference
      send_window(16'd0, MISSING_MARK, 16'd1000, 16'd1001, 16'd1002);
      // falling gap of two
      send_window(16'd1000, MISSING_MARK, MISSING_MARK, 16'd100, 16'd50);
      // equal bounds
      send_window(16'd500, MISSING_MARK, MISSING_MARK, 16'd500, 16'd500);
      // falling floor: 30 -> 0 over three, last step repeats
      send_window(16'd30, MISSING_MARK, MISSING_MARK, MISSING_MARK, 16'd0);
      // bit 15 on valid samples is ignored by the math but passed out as is
      send_window(16'h8064, MISSING_MARK, 16'h8100, 16'h8000, 16'h7FFF);
      // trailing source 0x7FFF fills as missing: pass through
      send_window(16'd1, 16'd2, 16'd3, 16'h7FFF, MISSING_MARK);
      // no history, leading source 0x7FFF: pass through
      send_window(MISSING_MARK, 16'h7FFF, 16'd5, 16'd6, 16'd7);
      // largest valid values everywhere
      send_window(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFE);
      // all zero, history becomes 0
      send_window(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      // four-sample gap from the history up to the top of range
      send_window(MISSING_MARK, MISSING_MARK, MISSING_MARK, MISSING_MARK, 16'h7FFE);
      // four-sample gap falling to zero
      send_window(MISSING_MARK, MISSING_MARK, MISSING_MARK, MISSING_MARK, 16'd0);
      // everything missing
      send_window(MISSING_MARK, MISSING_MARK, MISSING_MARK, MISSING_MARK, MISSING_MARK);
      // no history, only the newest valid: whole row from it
      send_window(MISSING_MARK, MISSING_MARK, MISSING_MARK, MISSING_MARK, 16'd5);
      // two separate single gaps
      send_window(16'd1, MISSING_MARK, 16'd3, MISSING_MARK, 16'd5);
      // full-range rising single gap
      send_window(16'd0, MISSING_MARK, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      // trailing source 0x8000 (value zero, flagged)
      send_window(16'd9, 16'd8, 16'd7, 16'h8000, MISSING_MARK);
      // gap of three rising with a bit-15 lower bound
      send_window(16'h8010, MISSING_MARK, MISSING_MARK, MISSING_MARK, 16'h0050);
      wait_drained();
   endtask

   // Random traffic with idling on both sides.
   task automatic test_random_windows(input int count);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (count) send_random_window();
      wait_drained();
   endtask

   // Receiver holds off while the sender keeps offering, so req_stall must rise.
   task automatic test_receiver_hold_off();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_asked++;
      repeat (40) send_random_window();
      wait_drained();
   endtask

   // Sender pauses until every response is back before each small group.
   task automatic test_drained_pauses();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (12) begin
         repeat ($urandom_range(1, 4)) send_random_window();
         wait_drained();
      end
   endtask

   // Last part: back to back on both sides.
   task automatic test_full_rate(input int count);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (count) send_random_window();
      wait_drained();
   endtask

   initial begin
      error_count    = 0;
      request_count  = 0;
      response_count = 0;
      repaired_count = 0;
      passthru_count = 0;
      hold_asked     = 0;
      req_idle_on    = 1'b0;
      rsp_idle_on    = 1'b0;
      model_history  = MISSING_MARK;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample_0   = '0;
      req_sample_1   = '0;
      req_sample_2   = '0;
      req_sample_3   = '0;
      req_sample_4   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_windows();
      test_random_windows(450);
      test_receiver_hold_off();
      test_drained_pauses();
      test_full_rate(150);

      // nothing more may come out
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (repaired_window_q.size() != 0)
         report_mismatch("responses missing at end", sample_type'(repaired_window_q.size()),
                         16'd0);

      $display("Sent %0d windows, checked %0d responses: %0d repaired, %0d passed through.",
               request_count, response_count, repaired_count, passthru_count);
      $display("Covered directed gap cases, random tracks, a long hold-off and full rate.");
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Timeout after %0d ns", RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rwgf_pkg.sv
rtl/rwgf_front.sv
rtl/rwgf_back.sv
rtl/ranging_window_gap_fill.sv
dv/testbench.sv
